FILE: rtl/srfv_pkg.sv
// shared types, constants and helper functions of the sorted record file validator
package srfv_pkg;

    localparam int INDEX_BITS_DEFAULT = 32;

    localparam int HEADER_BYTES = 16;
    localparam int TAG_BYTES    = 8;
    localparam int RECORD_BYTES = 20;

    // final status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_TOO_SHORT = 3'd1;
    localparam logic [2:0] STATUS_BAD_MAGIC = 3'd2;
    localparam logic [2:0] STATUS_SIZE      = 3'd3;
    localparam logic [2:0] STATUS_PADDING   = 3'd4;
    localparam logic [2:0] STATUS_ORDER     = 3'd5;

    // remembered record error codes
    localparam logic [1:0] REC_ERR_NONE    = 2'd0;
    localparam logic [1:0] REC_ERR_PADDING = 2'd1;
    localparam logic [1:0] REC_ERR_ORDER   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } srfv_in_t;

    typedef struct packed {
        logic        has_record;
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [7:0]  move_src;
        logic [7:0]  move_dst;
        logic [7:0]  promotion;
        logic [31:0] record_index;
        logic        is_final;
        logic [2:0]  status;
    } srfv_out_t;

    // expected header tag, one ascii byte per position
    function automatic logic [7:0] header_tag_byte(input logic [2:0] idx);
        logic [7:0] tag;
        unique case (idx)
            3'd0:    tag = 8'h47;
            3'd1:    tag = 8'h41;
            3'd2:    tag = 8'h52;
            3'd3:    tag = 8'h44;
            3'd4:    tag = 8'h4E;
            3'd5:    tag = 8'h45;
            3'd6:    tag = 8'h52;
            default: tag = 8'h31;
        endcase
        return tag;
    endfunction

endpackage

FILE: rtl/srfv_parser.sv
// file parser: header and record state, key order check and result formation
module srfv_parser #(
    parameter int INDEX_BITS = srfv_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  srfv_pkg::srfv_in_t   item,
    output logic                 emit,
    output srfv_pkg::srfv_out_t  result
);

    localparam logic [INDEX_BITS-1:0] COUNT_MAX = {INDEX_BITS{1'b1}};

    logic [4:0]            hp_reg, hp_next;
    logic                  magic_good_reg, magic_good_next;
    logic [63:0]           declared_reg, declared_next;
    logic [4:0]            rp_reg, rp_next;
    logic [63:0]           key_low_reg, key_low_next;
    logic [63:0]           key_high_reg, key_high_next;
    logic [23:0]           move_reg, move_next;
    logic [INDEX_BITS-1:0] seen_reg, seen_next;
    logic [63:0]           prev_low_reg, prev_low_next;
    logic [63:0]           prev_high_reg, prev_high_next;
    logic                  have_prev_reg, have_prev_next;
    logic [1:0]            first_err_reg, first_err_next;
    logic [INDEX_BITS-1:0] err_index_reg, err_index_next;

    logic                  in_header;
    logic                  complete;
    logic                  ascending;
    logic [2:0]            status;
    logic [63:0]           seen_wide;
    logic [63:0]           err_index_wide;
    logic [63:0]           seen_next_wide;

    assign in_header      = hp_reg < 5'(srfv_pkg::HEADER_BYTES);
    assign complete       = !in_header && (rp_reg >= 5'(srfv_pkg::RECORD_BYTES - 1));
    assign ascending      = {prev_low_reg, prev_high_reg} < {key_low_reg, key_high_reg};
    assign seen_wide      = 64'(seen_reg);
    assign seen_next_wide = 64'(seen_next);
    assign err_index_wide = 64'(err_index_next);

    always_comb
    begin
        hp_next         = hp_reg;
        magic_good_next = magic_good_reg;
        declared_next   = declared_reg;
        rp_next         = rp_reg;
        key_low_next    = key_low_reg;
        key_high_next   = key_high_reg;
        move_next       = move_reg;
        seen_next       = seen_reg;
        prev_low_next   = prev_low_reg;
        prev_high_next  = prev_high_reg;
        have_prev_next  = have_prev_reg;
        first_err_next  = first_err_reg;
        err_index_next  = err_index_reg;

        if (in_header)
        begin
            if (hp_reg < 5'(srfv_pkg::TAG_BYTES))
            begin
                if (item.data_byte != srfv_pkg::header_tag_byte(hp_reg[2:0]))
                begin
                    magic_good_next = 1'b0;
                end
            end
            else
            begin
                declared_next[{hp_reg[2:0], 3'b000} +: 8] =
                    declared_reg[{hp_reg[2:0], 3'b000} +: 8] | item.data_byte;
            end
            hp_next = hp_reg + 5'd1;
        end
        else if (complete)
        begin
            // padding byte closes the record
            if (first_err_reg == srfv_pkg::REC_ERR_NONE)
            begin
                if (item.data_byte != 8'd0)
                begin
                    first_err_next = srfv_pkg::REC_ERR_PADDING;
                    err_index_next = seen_reg;
                end
                else if (have_prev_reg && !ascending)
                begin
                    first_err_next = srfv_pkg::REC_ERR_ORDER;
                    err_index_next = seen_reg;
                end
            end
            prev_low_next  = key_low_reg;
            prev_high_next = key_high_reg;
            have_prev_next = 1'b1;
            if (seen_reg != COUNT_MAX)
            begin
                seen_next = seen_reg + 1'b1;
            end
            key_low_next  = 64'd0;
            key_high_next = 64'd0;
            move_next     = 24'd0;
            rp_next       = 5'd0;
        end
        else
        begin
            if (rp_reg < 5'd8)
            begin
                key_low_next[{rp_reg[2:0], 3'b000} +: 8] =
                    key_low_reg[{rp_reg[2:0], 3'b000} +: 8] | item.data_byte;
            end
            else if (rp_reg < 5'd16)
            begin
                key_high_next[{rp_reg[2:0], 3'b000} +: 8] =
                    key_high_reg[{rp_reg[2:0], 3'b000} +: 8] | item.data_byte;
            end
            else
            begin
                move_next[{rp_reg[1:0], 3'b000} +: 8] =
                    move_reg[{rp_reg[1:0], 3'b000} +: 8] | item.data_byte;
            end
            rp_next = rp_reg + 5'd1;
        end
    end

    // final status in priority order, from the updated state
    always_comb
    begin
        if (hp_next < 5'(srfv_pkg::HEADER_BYTES))
        begin
            status = srfv_pkg::STATUS_TOO_SHORT;
        end
        else if (!magic_good_next)
        begin
            status = srfv_pkg::STATUS_BAD_MAGIC;
        end
        else if (rp_next != 5'd0 || seen_next == COUNT_MAX ||
                 seen_next_wide != declared_next)
        begin
            status = srfv_pkg::STATUS_SIZE;
        end
        else
        begin
            case (first_err_next)
                srfv_pkg::REC_ERR_PADDING: status = srfv_pkg::STATUS_PADDING;
                srfv_pkg::REC_ERR_ORDER:   status = srfv_pkg::STATUS_ORDER;
                default:                   status = srfv_pkg::STATUS_OK;
            endcase
        end
    end

    always_comb
    begin
        emit = complete || item.last_byte;

        result              = '0;
        result.has_record   = complete;
        if (complete)
        begin
            result.key_low      = key_low_reg;
            result.key_high     = key_high_reg;
            result.move_src     = move_reg[7:0];
            result.move_dst     = move_reg[15:8];
            result.promotion    = move_reg[23:16];
            result.record_index = seen_wide[31:0];
        end
        if (item.last_byte)
        begin
            result.is_final = 1'b1;
            result.status   = status;
            if (status == srfv_pkg::STATUS_PADDING || status == srfv_pkg::STATUS_ORDER)
            begin
                result.record_index = err_index_wide[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg         <= 5'd0;
            magic_good_reg <= 1'b1;
            declared_reg   <= 64'd0;
            rp_reg         <= 5'd0;
            key_low_reg    <= 64'd0;
            key_high_reg   <= 64'd0;
            move_reg       <= 24'd0;
            seen_reg       <= '0;
            prev_low_reg   <= 64'd0;
            prev_high_reg  <= 64'd0;
            have_prev_reg  <= 1'b0;
            first_err_reg  <= srfv_pkg::REC_ERR_NONE;
            err_index_reg  <= '0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                // file done, start over for the next one
                hp_reg         <= 5'd0;
                magic_good_reg <= 1'b1;
                declared_reg   <= 64'd0;
                rp_reg         <= 5'd0;
                key_low_reg    <= 64'd0;
                key_high_reg   <= 64'd0;
                move_reg       <= 24'd0;
                seen_reg       <= '0;
                prev_low_reg   <= 64'd0;
                prev_high_reg  <= 64'd0;
                have_prev_reg  <= 1'b0;
                first_err_reg  <= srfv_pkg::REC_ERR_NONE;
                err_index_reg  <= '0;
            end
            else
            begin
                hp_reg         <= hp_next;
                magic_good_reg <= magic_good_next;
                declared_reg   <= declared_next;
                rp_reg         <= rp_next;
                key_low_reg    <= key_low_next;
                key_high_reg   <= key_high_next;
                move_reg       <= move_next;
                seen_reg       <= seen_next;
                prev_low_reg   <= prev_low_next;
                prev_high_reg  <= prev_high_next;
                have_prev_reg  <= have_prev_next;
                first_err_reg  <= first_err_next;
                err_index_reg  <= err_index_next;
            end
        end
    end

endmodule

FILE: rtl/sorted_record_file_validator_unit.sv
// top level of the sorted record file validator
// Checks a record file streamed in one byte per transaction, with last_byte set on the
// final byte. The file is a 16-byte header (8-byte tag, 8-byte little-endian record
// count) followed by 20-byte records (two little-endian 64-bit key words, three move
// bytes, one zero padding byte). A result transaction is sent for every completed record
// and one more, with is_final set, for the final byte; a final byte that also completes a
// record gives a single result carrying both. Final status, highest priority first: too
// short, bad tag, size mismatch, then the first nonzero padding or non-ascending key.
// Throughput is one byte per clock while no byte that makes a result meets a blocked
// result slot, limited only by the single parser step (one 128-bit key compare) between
// the input register and the result register. A result is registered in the result
// register as its byte leaves the input register, which is released while a result
// waits, so bytes that complete no record keep flowing during output stalls.
module sorted_record_file_validator_unit #(
    parameter int INDEX_BITS = srfv_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  srfv_pkg::srfv_in_t   byte_item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output srfv_pkg::srfv_out_t  result_item
);

    // input register
    logic                 in_valid_reg;
    srfv_pkg::srfv_in_t   in_item_reg;

    // result register
    logic                 out_valid_reg;
    srfv_pkg::srfv_out_t  out_item_reg;

    logic                 emit;
    logic                 step;
    srfv_pkg::srfv_out_t  parsed;

    srfv_parser #(
        .INDEX_BITS (INDEX_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .emit   (emit),
        .result (parsed)
    );

    // a held byte moves on unless it makes a result and the result slot is blocked
    assign step       = in_valid_reg && (!emit || !out_valid_reg || result_ready);
    assign byte_ready = !in_valid_reg || step;

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_valid && byte_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_item_reg <= byte_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_item_reg <= parsed;
        end
    end

endmodule
